[src/hrpc_pkg.sv]
// shared constants and types for the rotation pulse counter
package hrpc_pkg;

    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned PERIOD_W  = 8;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned QUALIFY_W = 3;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;

    localparam logic [TICK_W-1:0]    TICKS_PER_SECOND = 8'd200;
    localparam logic [QUALIFY_W-1:0] QUALIFY_LIMIT    = 3'd3;

    localparam logic                RST_ENABLE    = 1'b1;
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = 8'd0;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 10'd8;
    localparam logic [SAMPLE_W-1:0] RST_MIDPOINT  = 10'd511;

    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_PERIOD    = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_MIDPOINT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic step;
        logic clear;
    } ctrl_t;

endpackage

[src/hrpc_debounce.sv]
// distance from midpoint and debounced field on/off detector
module hrpc_debounce (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hrpc_pkg::ctrl_t                ctrl,
    input  logic [hrpc_pkg::SAMPLE_W-1:0]  sample,
    input  logic [hrpc_pkg::SAMPLE_W-1:0]  threshold,
    input  logic [hrpc_pkg::SAMPLE_W-1:0]  midpoint,
    output logic                           fall
);

    logic                           field_on_reg;
    logic                           field_on_next;
    logic [hrpc_pkg::QUALIFY_W-1:0] qualify_reg;
    logic [hrpc_pkg::QUALIFY_W-1:0] qualify_next;
    logic [hrpc_pkg::SAMPLE_W-1:0]  distance;
    logic [hrpc_pkg::QUALIFY_W-1:0] qualify_inc;
    logic                           moving;
    logic                           qualified;

    assign distance = (sample >= midpoint) ? (sample - midpoint) : (midpoint - sample);

    // exactly at threshold neither side counts
    assign moving = (!field_on_reg && (distance > threshold)) ||
                    (field_on_reg && (distance < threshold));

    assign qualify_inc = qualify_reg + 3'd1;
    assign qualified   = qualify_inc > hrpc_pkg::QUALIFY_LIMIT;

    assign fall = ctrl.step && moving && qualified && field_on_reg;

    always_comb
    begin
        field_on_next = field_on_reg;
        qualify_next  = qualify_reg;
        if (ctrl.clear)
        begin
            qualify_next = '0;
        end
        else if (ctrl.step && moving)
        begin
            if (qualified)
            begin
                qualify_next  = '0;
                field_on_next = !field_on_reg;
            end
            else
            begin
                qualify_next = qualify_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_on_reg <= 1'b0;
            qualify_reg  <= '0;
        end
        else
        begin
            field_on_reg <= field_on_next;
            qualify_reg  <= qualify_next;
        end
    end

    a_qualify_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        qualify_reg <= hrpc_pkg::QUALIFY_LIMIT)
        else $error("qualify count passed its limit");

endmodule

[src/hrpc_report.sv]
// rotation accumulator and seconds timer for period reports
module hrpc_report (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hrpc_pkg::ctrl_t                ctrl,
    input  logic                           fall,
    input  logic [hrpc_pkg::PERIOD_W-1:0]  period,
    output logic                           report_valid,
    output logic [hrpc_pkg::COUNT_W-1:0]   report_value
);

    logic [hrpc_pkg::COUNT_W-1:0]  total_reg;
    logic [hrpc_pkg::COUNT_W-1:0]  total_next;
    logic [hrpc_pkg::TICK_W-1:0]   tick_reg;
    logic [hrpc_pkg::TICK_W-1:0]   tick_next;
    logic [hrpc_pkg::PERIOD_W-1:0] second_reg;
    logic [hrpc_pkg::PERIOD_W-1:0] second_next;
    logic                          immediate;
    logic [hrpc_pkg::COUNT_W-1:0]  total_inc;
    logic [hrpc_pkg::TICK_W-1:0]   tick_inc;
    logic [hrpc_pkg::PERIOD_W-1:0] second_inc;
    logic                          second_wrap;
    logic                          period_done;

    assign immediate   = (period == '0);
    assign total_inc   = total_reg + {{(hrpc_pkg::COUNT_W-1){1'b0}}, (fall && !immediate)};
    assign tick_inc    = tick_reg + 8'd1;
    assign second_wrap = ctrl.step && (tick_inc >= hrpc_pkg::TICKS_PER_SECOND);
    assign second_inc  = second_reg + 8'd1;
    assign period_done = second_wrap && !immediate && (second_inc >= period);

    always_comb
    begin
        total_next  = total_reg;
        tick_next   = tick_reg;
        second_next = second_reg;
        if (ctrl.clear)
        begin
            total_next  = '0;
            tick_next   = '0;
            second_next = '0;
        end
        else if (ctrl.step)
        begin
            total_next = total_inc;
            tick_next  = tick_inc;
            if (second_wrap)
            begin
                tick_next = '0;
                if (!immediate)
                begin
                    second_next = second_inc;
                end
                if (period_done)
                begin
                    second_next = '0;
                    total_next  = '0;
                end
            end
        end
    end

    // immediate mode and a period report never fall on the same tick
    always_comb
    begin
        report_valid = 1'b0;
        report_value = '0;
        if (fall && immediate)
        begin
            report_valid = 1'b1;
            report_value = 16'd1;
        end
        else if (period_done)
        begin
            report_valid = 1'b1;
            report_value = total_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            tick_reg   <= '0;
            second_reg <= '0;
        end
        else
        begin
            total_reg  <= total_next;
            tick_reg   <= tick_next;
            second_reg <= second_next;
        end
    end

    a_tick_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg < hrpc_pkg::TICKS_PER_SECOND)
        else $error("tick count reached a full second without wrapping");

    a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (period == '0) |-> ((second_reg == '0) && (total_reg == '0)))
        else $error("counters moved in immediate mode");

    a_second_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (period != '0) |-> (second_reg < period))
        else $error("second count passed the report period");

endmodule

[src/hall_rotation_pulse_counter_core.sv]
// top level: register file, sample and result stages, detector and report logic
// each sample is registered in the sample stage, then moves into the result register when the pipe advances
// throughput: one sample per cycle while results are taken, set by the single stage between input and result registers
// the result register frees as it is taken, so a stalled result only holds the pipe when full
// reset: enable 1, period 0, threshold 8, midpoint 511, field absent, all counters zero
module hall_rotation_pulse_counter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hrpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [hrpc_pkg::DATA_W-1:0]   pwdata,
    output logic [hrpc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [hrpc_pkg::SAMPLE_W-1:0] sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          rotation_pulse,
    output logic                          report_valid,
    output logic [hrpc_pkg::COUNT_W-1:0]  report_value
);

    logic                          enable_reg;
    logic [hrpc_pkg::PERIOD_W-1:0] period_reg;
    logic [hrpc_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [hrpc_pkg::SAMPLE_W-1:0] midpoint_reg;
    hrpc_pkg::reg_idx_t            reg_idx;
    logic                          cfg_write;

    logic                          s1_valid_reg;
    logic [hrpc_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          result_valid_reg;
    logic                          pulse_reg;
    logic                          report_valid_reg;
    logic [hrpc_pkg::COUNT_W-1:0]  report_value_reg;

    logic                          advance;
    logic                          fire;
    hrpc_pkg::ctrl_t               ctrl;
    logic                          fall;
    logic                          rep_valid;
    logic [hrpc_pkg::COUNT_W-1:0]  rep_value;

    assign pready    = 1'b1;
    assign reg_idx   = hrpc_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= hrpc_pkg::RST_ENABLE;
            period_reg    <= hrpc_pkg::RST_PERIOD;
            threshold_reg <= hrpc_pkg::RST_THRESHOLD;
            midpoint_reg  <= hrpc_pkg::RST_MIDPOINT;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                hrpc_pkg::REG_ENABLE:    enable_reg    <= pwdata[0];
                hrpc_pkg::REG_PERIOD:    period_reg    <= pwdata[hrpc_pkg::PERIOD_W-1:0];
                hrpc_pkg::REG_THRESHOLD: threshold_reg <= pwdata[hrpc_pkg::SAMPLE_W-1:0];
                hrpc_pkg::REG_MIDPOINT:  midpoint_reg  <= pwdata[hrpc_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            hrpc_pkg::REG_ENABLE:    prdata[0] = enable_reg;
            hrpc_pkg::REG_PERIOD:    prdata[hrpc_pkg::PERIOD_W-1:0] = period_reg;
            hrpc_pkg::REG_THRESHOLD: prdata[hrpc_pkg::SAMPLE_W-1:0] = threshold_reg;
            hrpc_pkg::REG_MIDPOINT:  prdata[hrpc_pkg::SAMPLE_W-1:0] = midpoint_reg;
            default: ;
        endcase
    end

    // pipe moves whenever the result register is empty or being taken
    assign advance      = !result_valid_reg || result_ready;
    assign fire         = s1_valid_reg && advance;
    assign sample_ready = !s1_valid_reg || advance;

    assign ctrl.step  = fire && enable_reg;
    assign ctrl.clear = cfg_write && (reg_idx == hrpc_pkg::REG_PERIOD);

    hrpc_debounce u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample    (sample_reg),
        .threshold (threshold_reg),
        .midpoint  (midpoint_reg),
        .fall      (fall)
    );

    hrpc_report u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .fall         (fall),
        .period       (period_reg),
        .report_valid (rep_valid),
        .report_value (rep_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                result_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            sample_reg <= sample;
        end
        if (fire)
        begin
            pulse_reg        <= fall;
            report_valid_reg <= rep_valid;
            report_value_reg <= rep_value;
        end
    end

    assign result_valid   = result_valid_reg;
    assign rotation_pulse = pulse_reg;
    assign report_valid   = report_valid_reg;
    assign report_value   = report_value_reg;

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(sample_reg)))
        else $error("sample stage lost its request during a stall");

endmodule

[tb/tb.sv]
// self-checking bench for the rotation pulse counter: sample requests in, checked results out
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [hrpc_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic [hrpc_pkg::DATA_W-1:0]   word_t;

    typedef struct packed {
        logic                         pulse;
        logic                         report_valid;
        logic [hrpc_pkg::COUNT_W-1:0] report_value;
    } rot_result_t;

    typedef enum int {SK_FAR, SK_NEAR, SK_EQUAL} sample_kind_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [hrpc_pkg::ADDR_W-1:0]   paddr = '0;
    word_t                         pwdata = '0;
    word_t                         prdata;
    logic                          pready;
    logic                          sample_valid = 1'b0;
    logic                          sample_ready;
    sample_t                       sample = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic                          rotation_pulse;
    logic                          report_valid;
    logic [hrpc_pkg::COUNT_W-1:0]  report_value;

    // detector copy, register copies start at their reset values
    logic                           cfg_enable = hrpc_pkg::RST_ENABLE;
    logic [hrpc_pkg::PERIOD_W-1:0]  cfg_period = hrpc_pkg::RST_PERIOD;
    sample_t                        cfg_threshold = hrpc_pkg::RST_THRESHOLD;
    sample_t                        cfg_midpoint = hrpc_pkg::RST_MIDPOINT;
    logic                           det_field_on = 1'b0;
    logic [hrpc_pkg::QUALIFY_W-1:0] det_qualify = '0;
    logic [hrpc_pkg::COUNT_W-1:0]   det_rotations = '0;
    logic [hrpc_pkg::TICK_W-1:0]    det_ticks = '0;
    logic [hrpc_pkg::PERIOD_W-1:0]  det_seconds = '0;

    sample_t             samples_pending [$];
    rot_result_t         expected_results [$];
    logic                sample_taken = 1'b0;
    logic                idle_en = 1'b0;
    int                  send_gap = 0;
    int                  ready_hold = 0;
    int                  errors = 0;

    sample_t directed_samples [0:22] = '{
        10'd0, 10'd0, 10'd0, 10'd0, 10'd519, 10'd503, 10'd1023, 10'd511, 10'd511, 10'd511,
        10'd519, 10'd512, 10'd1023, 10'd1023, 10'd511, 10'd0, 10'd519, 10'd520, 10'd510,
        10'd300, 10'd511, 10'd511, 10'd511
    };

    hall_rotation_pulse_counter_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .rotation_pulse (rotation_pulse),
        .report_valid   (report_valid),
        .report_value   (report_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic rot_result_t advance_detector(input sample_t s);
        rot_result_t r;
        sample_t     distance;
        r = '0;
        if (cfg_enable)
        begin
            distance = (s >= cfg_midpoint) ? s - cfg_midpoint : cfg_midpoint - s;
            // a distance equal to the threshold counts towards neither edge
            if ((!det_field_on && distance > cfg_threshold) ||
                (det_field_on && distance < cfg_threshold))
            begin
                det_qualify = det_qualify + 1'b1;
                if (det_qualify > hrpc_pkg::QUALIFY_LIMIT)
                begin
                    det_qualify = '0;
                    if (det_field_on)
                    begin
                        r.pulse = 1'b1;
                        if (cfg_period == '0)
                        begin
                            r.report_valid = 1'b1;
                            r.report_value = 16'd1;
                        end
                        else
                            det_rotations = det_rotations + 1'b1;
                    end
                    det_field_on = !det_field_on;
                end
            end
            det_ticks = det_ticks + 1'b1;
            if (det_ticks >= hrpc_pkg::TICKS_PER_SECOND)
            begin
                det_ticks = '0;
                if (cfg_period != '0)
                begin
                    det_seconds = det_seconds + 1'b1;
                    if (det_seconds >= cfg_period)
                    begin
                        r.report_valid = 1'b1;
                        r.report_value = det_rotations;
                        det_rotations = '0;
                        det_seconds = '0;
                    end
                end
            end
        end
        return r;
    endfunction

    // a sample on the chosen side of the threshold, any sample where that side cannot be reached
    function automatic sample_t pick_sample(input sample_kind_t kind);
        int m;
        int t;
        int lo;
        int hi;
        m = int'(cfg_midpoint);
        t = int'(cfg_threshold);
        case (kind)
            SK_FAR:
            begin
                if (m + t + 1 <= 1023 && (m < t + 1 || $urandom_range(0, 1) == 1))
                    return sample_t'($urandom_range(m + t + 1, 1023));
                if (m >= t + 1)
                    return sample_t'($urandom_range(0, m - t - 1));
            end
            SK_NEAR:
            begin
                if (t > 0)
                begin
                    lo = (m - t + 1 < 0) ? 0 : m - t + 1;
                    hi = (m + t - 1 > 1023) ? 1023 : m + t - 1;
                    return sample_t'($urandom_range(lo, hi));
                end
            end
            SK_EQUAL:
            begin
                if (m + t <= 1023 && (m < t || $urandom_range(0, 1) == 1))
                    return sample_t'(m + t);
                if (m >= t)
                    return sample_t'(m - t);
            end
            default: ;
        endcase
        return sample_t'($urandom_range(0, 1023));
    endfunction

    // request acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
        begin
            expected_results.push_back(advance_detector(sample));
            sample_taken = 1'b1;
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        if (!(sample_valid && !sample_taken))
        begin
            sample_taken = 1'b0;
            if (send_gap > 0)
            begin
                sample_valid <= 1'b0;
                send_gap--;
            end
            else if (rst_n && samples_pending.size() != 0)
            begin
                sample <= samples_pending.pop_front();
                sample_valid <= 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 12);
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // result stalls
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            result_ready <= 1'b0;
            ready_hold--;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            result_ready <= 1'b0;
            ready_hold = $urandom_range(0, 11);
        end
        else
            result_ready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        rot_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: pulse %0d valid %0d value %0d",
                       rotation_pulse, report_valid, report_value);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rotation_pulse !== want.pulse)
                begin
                    $error("rotation_pulse: expected %0d, got %0d", want.pulse, rotation_pulse);
                    errors++;
                end
                if (report_valid !== want.report_valid)
                begin
                    $error("report_valid: expected %0d, got %0d", want.report_valid, report_valid);
                    errors++;
                end
                if (report_value !== want.report_value)
                begin
                    $error("report_value: expected %0d, got %0d", want.report_value, report_value);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input hrpc_pkg::reg_idx_t idx, input word_t val);
        word_t readback;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            hrpc_pkg::REG_ENABLE:    cfg_enable = val[0];
            hrpc_pkg::REG_PERIOD:
            begin
                cfg_period = val[hrpc_pkg::PERIOD_W-1:0];
                det_qualify = '0;
                det_rotations = '0;
                det_ticks = '0;
                det_seconds = '0;
            end
            hrpc_pkg::REG_THRESHOLD: cfg_threshold = val[hrpc_pkg::SAMPLE_W-1:0];
            hrpc_pkg::REG_MIDPOINT:  cfg_midpoint = val[hrpc_pkg::SAMPLE_W-1:0];
            default: ;
        endcase
        case (idx)
            hrpc_pkg::REG_ENABLE:    readback = word_t'(cfg_enable);
            hrpc_pkg::REG_PERIOD:    readback = word_t'(cfg_period);
            hrpc_pkg::REG_THRESHOLD: readback = word_t'(cfg_threshold);
            default:                 readback = word_t'(cfg_midpoint);
        endcase
        // read the register straight back
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== readback)
        begin
            $error("prdata: expected %0h, got %0h", readback, prdata);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly field-on / field-off runs, with some raw noise
    task automatic queue_rotations(input int count);
        int queued;
        int run;
        int i;
        queued = 0;
        @(posedge clk);
        while (queued < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                run = $urandom_range(3, 9);
                for (i = 0; i < run; i++)
                    samples_pending.push_back(
                        pick_sample($urandom_range(0, 7) == 0 ? SK_EQUAL : SK_FAR));
                queued += run;
                run = $urandom_range(3, 9);
                for (i = 0; i < run; i++)
                    samples_pending.push_back(
                        pick_sample($urandom_range(0, 7) == 0 ? SK_EQUAL : SK_NEAR));
                queued += run;
            end
            else
            begin
                run = $urandom_range(1, 6);
                for (i = 0; i < run; i++)
                    samples_pending.push_back(sample_t'($urandom_range(0, 1023)));
                queued += run;
            end
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while (samples_pending.size() != 0 || sample_valid)
            @(negedge clk);
        while (expected_results.size() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
            expected_results.delete();
        end
        repeat (6) @(negedge clk);
    endtask

    initial
    begin
        int n;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_samples[i])
            samples_pending.push_back(directed_samples[i]);
        wait_drained();

        for (int p = 0; p < 7; p++)
        begin
            idle_en = (p != 6);
            case (p)
                0:
                begin
                    write_reg(hrpc_pkg::REG_PERIOD, 1);
                    n = 500;
                end
                1:
                begin
                    write_reg(hrpc_pkg::REG_PERIOD, 2);
                    write_reg(hrpc_pkg::REG_THRESHOLD, $urandom_range(1, 300));
                    write_reg(hrpc_pkg::REG_MIDPOINT, $urandom_range(0, 1023));
                    n = 450;
                end
                2:
                begin
                    write_reg(hrpc_pkg::REG_PERIOD, 0);
                    write_reg(hrpc_pkg::REG_THRESHOLD, 0);
                    write_reg(hrpc_pkg::REG_MIDPOINT, 0);
                    n = 150;
                end
                3:
                begin
                    write_reg(hrpc_pkg::REG_ENABLE, 0);
                    n = 60;
                end
                4:
                begin
                    write_reg(hrpc_pkg::REG_ENABLE, 1);
                    write_reg(hrpc_pkg::REG_PERIOD, 255);
                    write_reg(hrpc_pkg::REG_THRESHOLD, 1023);
                    write_reg(hrpc_pkg::REG_MIDPOINT, 1023);
                    n = 100;
                end
                5:
                begin
                    write_reg(hrpc_pkg::REG_PERIOD, 1);
                    write_reg(hrpc_pkg::REG_THRESHOLD, $urandom_range(0, 200));
                    write_reg(hrpc_pkg::REG_MIDPOINT, $urandom_range(0, 1023));
                    n = 300;
                end
                default:
                begin
                    write_reg(hrpc_pkg::REG_PERIOD, 1);
                    write_reg(hrpc_pkg::REG_THRESHOLD, 5);
                    write_reg(hrpc_pkg::REG_MIDPOINT, 700);
                    n = 400;
                end
            endcase
            queue_rotations(n);
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
